@@ rtl/tcwe_pkg.sv @@
package tcwe_pkg;

	localparam int WIN_REGS       = 3;
	localparam int COORD_W        = 12;
	localparam int CFG_IDX_W      = 3;
	localparam int ENTRY_W        = 32;
	localparam int TILE_NUM_W     = 12;
	localparam int POS_W          = 7;
	localparam int OFFSET_W       = 13;
	localparam int LAYER_W        = 2;

	localparam int TILE_COUNT_DEF    = 4096;
	localparam int WINDOW_WIDTH_DEF  = 16;
	localparam int WINDOW_HEIGHT_DEF = 12;
	localparam int LAYERS_DEF        = 3;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TILE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN0_X = 3'd0,
		REG_WIN0_Y = 3'd1,
		REG_WIN1_X = 3'd2,
		REG_WIN1_Y = 3'd3,
		REG_WIN2_X = 3'd4,
		REG_WIN2_Y = 3'd5
	} cfg_reg_t;

	typedef logic [WIN_REGS-1:0][COORD_W-1:0] win_coord_t;

endpackage

@@ rtl/tcwe_ram.sv @@
module tcwe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tcwe_wrap.sv @@
module tcwe_wrap
	import tcwe_pkg::*;
#(
	parameter int TILE_COUNT = TILE_COUNT_DEF
) (
	input  logic [TILE_NUM_W-1:0]         num,
	output logic [$clog2(TILE_COUNT)-1:0] idx
);

	localparam logic [16:0] TC = 17'(TILE_COUNT);

	logic [TILE_NUM_W:0] rem;

	// restoring reduction: the quotient never exceeds 31 for the allowed counts
	always_comb begin
		rem = {1'b0, num};
		for (int k = 4; k >= 0; k--) begin
			if ({4'b0, rem} >= (TC << k)) begin
				rem = (TILE_NUM_W+1)'({4'b0, rem} - (TC << k));
			end
		end
		idx = rem[$clog2(TILE_COUNT)-1:0];
	end

endmodule

@@ rtl/tcwe_cover.sv @@
module tcwe_cover
	import tcwe_pkg::*;
#(
	parameter int WINDOW_WIDTH  = WINDOW_WIDTH_DEF,
	parameter int WINDOW_HEIGHT = WINDOW_HEIGHT_DEF,
	parameter int NWIN          = LAYERS_DEF
) (
	input  logic [POS_W-1:0] col,
	input  logic [POS_W-1:0] row,
	input  win_coord_t       win_x,
	input  win_coord_t       win_y,
	output logic [NWIN-1:0]  hit
);

	localparam int CW = COORD_W + 2;

	logic signed [CW-1:0] col_s;
	logic signed [CW-1:0] row_s;

	assign col_s = signed'({(CW-POS_W)'(0), col});
	assign row_s = signed'({(CW-POS_W)'(0), row});

	always_comb begin
		logic signed [CW-1:0] x_lo;
		logic signed [CW-1:0] y_lo;
		logic signed [CW-1:0] x_hi;
		logic signed [CW-1:0] y_hi;
		for (int i = 0; i < NWIN; i++) begin
			x_lo = CW'(signed'(win_x[i]));
			y_lo = CW'(signed'(win_y[i]));
			x_hi = x_lo + CW'(WINDOW_WIDTH);
			y_hi = y_lo + CW'(WINDOW_HEIGHT);
			hit[i] = (col_s >= x_lo) && (col_s < x_hi) && (row_s >= y_lo) && (row_s < y_hi);
		end
	end

endmodule

@@ rtl/tilemap_copy_window_expose.sv @@
// A tile word is registered in stage 1, then in stage 2, then in the output register, and so reaches the output.
// Throughput: one word per cycle while in_stall is low, tile or load; a load word yields no result.
// Stages: table read and register, window compare, priority pick into the output register.
// Reset (arst_n low): pipeline empties and window registers clear to zero.
// Pattern table contents are undefined after reset until loaded.
module tilemap_copy_window_expose
	import tcwe_pkg::*;
#(
	parameter int TILE_COUNT    = TILE_COUNT_DEF,
	parameter int WINDOW_WIDTH  = WINDOW_WIDTH_DEF,
	parameter int WINDOW_HEIGHT = WINDOW_HEIGHT_DEF,
	parameter int LAYERS        = LAYERS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_W-1:0]    cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [POS_W-1:0]      tile_col,
	input  logic [POS_W-1:0]      tile_row,
	input  logic [ENTRY_W-1:0]    src_entry,
	input  logic [ENTRY_W-1:0]    old_dest_entry,
	input  logic [TILE_NUM_W-1:0] table_index,
	input  logic [ENTRY_W-1:0]    table_word0,
	input  logic [ENTRY_W-1:0]    table_word1,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ENTRY_W-1:0]    new_dest_entry,
	output logic                  exposed,
	output logic [LAYER_W-1:0]    hit_layer,
	output logic [OFFSET_W-1:0]   disp_offset,
	output logic [ENTRY_W-1:0]    pattern_word0,
	output logic [ENTRY_W-1:0]    pattern_word1
);

	localparam int AW   = $clog2(TILE_COUNT);
	localparam int NWIN = (LAYERS < WIN_REGS) ? LAYERS : WIN_REGS;

	win_coord_t win_x_q;
	win_coord_t win_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_x_q <= '0;
			win_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIN0_X: win_x_q[0] <= cfg_data;
				REG_WIN0_Y: win_y_q[0] <= cfg_data;
				REG_WIN1_X: win_x_q[1] <= cfg_data;
				REG_WIN1_Y: win_y_q[1] <= cfg_data;
				REG_WIN2_X: win_x_q[2] <= cfg_data;
				REG_WIN2_Y: win_y_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: each stage moves when the next one has room
	logic v_s1, v_s2, v_s3;
	logic ready_s1, ready_s2, ready_s3;
	logic in_acc, tile_acc, load_acc;

	assign ready_s3 = !v_s3 || !out_stall;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_stall = !ready_s1;
	assign in_acc   = in_valid && ready_s1;
	assign tile_acc = in_acc && (opcode == OP_TILE);
	assign load_acc = in_acc && (opcode == OP_LOAD);

	logic [AW-1:0]          rd_idx;
	logic [AW-1:0]          wr_idx;
	logic [2*ENTRY_W-1:0]   rd_data;

	tcwe_wrap #(.TILE_COUNT(TILE_COUNT)) u_wrap_rd (
		.num (src_entry[TILE_NUM_W-1:0]),
		.idx (rd_idx)
	);

	tcwe_wrap #(.TILE_COUNT(TILE_COUNT)) u_wrap_wr (
		.num (table_index),
		.idx (wr_idx)
	);

	// read data is held while stage 1 holds, since reads fire only on accept
	tcwe_ram #(.WIDTH(2*ENTRY_W), .DEPTH(TILE_COUNT)) u_table (
		.clk   (clk),
		.we    (load_acc),
		.waddr (wr_idx),
		.wdata ({table_word1, table_word0}),
		.re    (tile_acc),
		.raddr (rd_idx),
		.rdata (rd_data)
	);

	// stage 1
	logic [POS_W-1:0]          col_s1, row_s1;
	logic [ENTRY_W-1:0]        new_dest_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= tile_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (tile_acc) begin
			col_s1      <= tile_col;
			row_s1      <= tile_row;
			new_dest_s1 <= {old_dest_entry[ENTRY_W-1:TILE_NUM_W],
				src_entry[TILE_NUM_W-1:0]};
		end
	end

	logic [NWIN-1:0] hit;

	tcwe_cover #(
		.WINDOW_WIDTH  (WINDOW_WIDTH),
		.WINDOW_HEIGHT (WINDOW_HEIGHT),
		.NWIN          (NWIN)
	) u_cover (
		.col   (col_s1),
		.row   (row_s1),
		.win_x (win_x_q),
		.win_y (win_y_q),
		.hit   (hit)
	);

	// stage 2
	logic [NWIN-1:0]    hit_s2;
	logic [3:0]         cell_col_s2, cell_row_s2;
	logic [ENTRY_W-1:0] new_dest_s2, pw0_s2, pw1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			hit_s2      <= hit;
			cell_col_s2 <= col_s1[3:0];
			cell_row_s2 <= row_s1[3:0];
			new_dest_s2 <= new_dest_s1;
			pw0_s2      <= rd_data[ENTRY_W-1:0];
			pw1_s2      <= rd_data[2*ENTRY_W-1:ENTRY_W];
		end
	end

	// first covering window wins
	logic               found;
	logic [LAYER_W-1:0] layer;

	always_comb begin
		found = 1'b0;
		layer = '0;
		for (int i = NWIN - 1; i >= 0; i--) begin
			if (hit_s2[i]) begin
				found = 1'b1;
				layer = LAYER_W'(i);
			end
		end
	end

	// stage 3: output register
	logic [ENTRY_W-1:0]  new_dest_s3, pw0_s3, pw1_s3;
	logic                exposed_s3;
	logic [LAYER_W-1:0]  layer_s3;
	logic [OFFSET_W-1:0] offset_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			new_dest_s3 <= new_dest_s2;
			exposed_s3  <= found;
			layer_s3    <= found ? layer : '0;
			offset_s3   <= found ? {layer, cell_row_s2, 1'b0, cell_col_s2, 2'b00} : '0;
			pw0_s3      <= found ? pw0_s2 : '0;
			pw1_s3      <= found ? pw1_s2 : '0;
		end
	end

	assign out_valid      = v_s3;
	assign new_dest_entry = new_dest_s3;
	assign exposed        = exposed_s3;
	assign hit_layer      = layer_s3;
	assign disp_offset    = offset_s3;
	assign pattern_word0  = pw0_s3;
	assign pattern_word1  = pw1_s3;

endmodule

@@ verif/tilemap_copy_window_expose_test.sv @@
module tilemap_copy_window_expose_test;
	import tcwe_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 64;
	localparam int DRAIN_WAIT  = 6;
	localparam cfg_reg_t WIN_REG_ORDER [6] = '{REG_WIN0_X, REG_WIN0_Y, REG_WIN1_X,
		REG_WIN1_Y, REG_WIN2_X, REG_WIN2_Y};

	typedef struct packed {
		logic [ENTRY_W-1:0]  new_dest;
		logic                exposed;
		logic [LAYER_W-1:0]  layer;
		logic [OFFSET_W-1:0] offset;
		logic [ENTRY_W-1:0]  word0;
		logic [ENTRY_W-1:0]  word1;
	} tile_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [COORD_W-1:0]    cfg_data = '0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  opcode = OP_LOAD;
	logic [POS_W-1:0]      tile_col = '0;
	logic [POS_W-1:0]      tile_row = '0;
	logic [ENTRY_W-1:0]    src_entry = '0;
	logic [ENTRY_W-1:0]    old_dest_entry = '0;
	logic [TILE_NUM_W-1:0] table_index = '0;
	logic [ENTRY_W-1:0]    table_word0 = '0;
	logic [ENTRY_W-1:0]    table_word1 = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ENTRY_W-1:0]    new_dest_entry;
	logic                  exposed;
	logic [LAYER_W-1:0]    hit_layer;
	logic [OFFSET_W-1:0]   disp_offset;
	logic [ENTRY_W-1:0]    pattern_word0;
	logic [ENTRY_W-1:0]    pattern_word1;

	// predictor state
	logic [COORD_W-1:0]   win_reg [6];
	logic [2*ENTRY_W-1:0] pattern_mem [TILE_COUNT_DEF];
	bit                   pattern_loaded [TILE_COUNT_DEF];
	logic [TILE_NUM_W-1:0] loaded_tiles [$];
	tile_result_t         pending_results [$];

	int  mismatches = 0;
	int  cycle_count = 0;
	bit  src_idle_en = 1'b0;
	bit  sink_idle_en = 1'b0;
	bit  hold_start = 1'b0;
	int  hold_left = 0;
	int  sink_burst = 0;

	tilemap_copy_window_expose dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.tile_col(tile_col), .tile_row(tile_row), .src_entry(src_entry),
		.old_dest_entry(old_dest_entry), .table_index(table_index),
		.table_word0(table_word0), .table_word1(table_word1),
		.out_valid(out_valid), .out_stall(out_stall), .new_dest_entry(new_dest_entry),
		.exposed(exposed), .hit_layer(hit_layer), .disp_offset(disp_offset),
		.pattern_word0(pattern_word0), .pattern_word1(pattern_word1)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
			$display("tilemap_copy_window_expose_test NOT OK");
			$finish;
		end
	end

	function automatic tile_result_t merge_and_expose(logic [POS_W-1:0] col,
			logic [POS_W-1:0] row, logic [ENTRY_W-1:0] src, logic [ENTRY_W-1:0] old);
		tile_result_t res;
		int c, r, wx, wy;
		c = int'(col);
		r = int'(row);
		res = '0;
		res.new_dest = {old[ENTRY_W-1:TILE_NUM_W], src[TILE_NUM_W-1:0]};
		for (int l = 0; l < LAYERS_DEF; l++) begin
			wx = int'($signed(win_reg[2*l]));
			wy = int'($signed(win_reg[2*l+1]));
			if (c >= wx && c < wx + WINDOW_WIDTH_DEF &&
					r >= wy && r < wy + WINDOW_HEIGHT_DEF) begin
				res.exposed = 1'b1;
				res.layer = LAYER_W'(l);
				res.offset = OFFSET_W'(l*2048 + ((r % 16)*32 + (c % 16))*4);
				{res.word0, res.word1} = pattern_mem[src[TILE_NUM_W-1:0]];
				break;
			end
		end
		return res;
	endfunction

	task automatic check_field(string name, logic [ENTRY_W-1:0] want,
			logic [ENTRY_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// compare each result word, then decide the stall for the next cycle
	always @(posedge clk) begin : result_check
		tile_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $time,
					new_dest_entry);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("new_dest_entry", want.new_dest, new_dest_entry);
				check_field("exposed", ENTRY_W'(want.exposed), ENTRY_W'(exposed));
				check_field("hit_layer", ENTRY_W'(want.layer), ENTRY_W'(hit_layer));
				check_field("disp_offset", ENTRY_W'(want.offset), ENTRY_W'(disp_offset));
				check_field("pattern_word0", want.word0, pattern_word0);
				check_field("pattern_word1", want.word1, pattern_word1);
			end
		end
		if (hold_start) begin
			hold_left = LONG_HOLD;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (sink_burst > 0) begin
			sink_burst--;
			out_stall <= 1'b1;
		end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
			sink_burst = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// leaves valid high so a following word can go out back to back
	task automatic send_word(op_t op, logic [POS_W-1:0] col, logic [POS_W-1:0] row,
			logic [ENTRY_W-1:0] src, logic [ENTRY_W-1:0] old,
			logic [TILE_NUM_W-1:0] idx, logic [ENTRY_W-1:0] w0, logic [ENTRY_W-1:0] w1);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		tile_col <= col;
		tile_row <= row;
		src_entry <= src;
		old_dest_entry <= old;
		table_index <= idx;
		table_word0 <= w0;
		table_word1 <= w1;
		do @(posedge clk); while (in_stall);
		if (op == OP_LOAD) begin
			pattern_mem[idx] = {w0, w1};
			if (!pattern_loaded[idx]) begin
				pattern_loaded[idx] = 1'b1;
				loaded_tiles.push_back(idx);
			end
		end else begin
			pending_results.push_back(merge_and_expose(col, row, src, old));
		end
	endtask

	task automatic load_entry(logic [TILE_NUM_W-1:0] idx, logic [ENTRY_W-1:0] w0,
			logic [ENTRY_W-1:0] w1);
		send_word(OP_LOAD, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom,
			idx, w0, w1);
	endtask

	task automatic copy_tile(logic [POS_W-1:0] col, logic [POS_W-1:0] row,
			logic [ENTRY_W-1:0] src, logic [ENTRY_W-1:0] old);
		send_word(OP_TILE, col, row, src, old, TILE_NUM_W'($urandom), $urandom,
			$urandom);
	endtask

	function automatic logic [TILE_NUM_W-1:0] pick_loaded();
		return loaded_tiles[$urandom_range(0, loaded_tiles.size() - 1)];
	endfunction

	function automatic int rand_coord();
		if ($urandom_range(0, 5) == 0)
			return int'($urandom_range(0, 4095)) - 2048;
		return int'($urandom_range(0, 143)) - 16;
	endfunction

	// drop valid, wait out every result and the load words behind it
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_windows(int x0, int y0, int x1, int y1, int x2, int y2);
		logic [COORD_W-1:0] vals [6];
		vals[0] = x0[COORD_W-1:0];
		vals[1] = y0[COORD_W-1:0];
		vals[2] = x1[COORD_W-1:0];
		vals[3] = y1[COORD_W-1:0];
		vals[4] = x2[COORD_W-1:0];
		vals[5] = y2[COORD_W-1:0];
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= WIN_REG_ORDER[i];
			cfg_data <= vals[i];
			@(posedge clk);
			win_reg[WIN_REG_ORDER[i]] = vals[i];
		end
		cfg_we <= 1'b0;
	endtask

	// windows still at reset: all three sit at the origin, so layer 0 wins
	task automatic test_reset_windows();
		load_entry(12'h000, 32'h0000_0000, 32'hFFFF_FFFF);
		load_entry(12'hFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		load_entry(12'h5A5, 32'hA5A5_5A5A, 32'h1234_5678);
		copy_tile(7'd0, 7'd0, 32'hFFFF_F000, 32'hFFFF_FFFF);
		copy_tile(7'd15, 7'd11, 32'h0000_0FFF, 32'h0000_0000);
		copy_tile(7'd16, 7'd0, 32'hFFFF_FFFF, 32'h1234_5FFF);
		copy_tile(7'd0, 7'd12, 32'h0000_05A5, 32'hFFFF_F000);
		copy_tile(7'd127, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// overlapping windows pick the lowest layer; load then read the same entry
	task automatic test_layer_priority();
		set_windows(10, 10, 0, 0, 20, 5);
		load_entry(12'h321, 32'hDEAD_BEEF, 32'hCAFE_F00D);
		copy_tile(7'd12, 7'd10, 32'h0000_0321, 32'h8000_0000);
		load_entry(12'h321, 32'h0BAD_F00D, 32'h7777_8888);
		copy_tile(7'd3, 7'd4, 32'h0000_0321, 32'h0000_0001);
		copy_tile(7'd25, 7'd16, 32'h0000_05A5, 32'h0000_0002);
		copy_tile(7'd35, 7'd16, 32'h0000_05A5, 32'h0000_0003);
		wait_drained();
	endtask

	// coordinate extremes and windows that only just reach the map edges
	task automatic test_window_extremes();
		set_windows(-2048, -2048, 2047, 2047, -15, -11);
		copy_tile(7'd0, 7'd0, 32'h0000_0FFF, 32'h0000_0000);
		copy_tile(7'd1, 7'd0, 32'h0000_0FFF, 32'h0000_0000);
		copy_tile(7'd0, 7'd1, 32'h0000_0000, 32'hFFFF_FFFF);
		wait_drained();
		set_windows(112, 116, 2047, -2048, -2048, 2047);
		copy_tile(7'd127, 7'd127, 32'h0000_0FFF, 32'hFFFF_FFFF);
		copy_tile(7'd112, 7'd116, 32'h0000_0000, 32'h0000_0000);
		copy_tile(7'd111, 7'd127, 32'h0000_05A5, 32'h0000_0000);
		wait_drained();
	endtask

	task automatic random_word();
		int l, wx, wy, c, r;
		logic [ENTRY_W-1:0] src;
		if ($urandom_range(0, 4) == 0) begin
			if ($urandom_range(0, 3) == 0)
				load_entry(pick_loaded(), $urandom, $urandom);
			else
				load_entry(TILE_NUM_W'($urandom), $urandom, $urandom);
		end else begin
			c = $urandom_range(0, 127);
			r = $urandom_range(0, 127);
			if ($urandom_range(0, 1)) begin
				// aim near a window, edges included
				l = $urandom_range(0, LAYERS_DEF - 1);
				wx = int'($signed(win_reg[2*l]));
				wy = int'($signed(win_reg[2*l+1]));
				if (wx + 17 >= 0 && wx - 1 <= 127)
					c = wx + int'($urandom_range(0, WINDOW_WIDTH_DEF + 1)) - 1;
				if (wy + 13 >= 0 && wy - 1 <= 127)
					r = wy + int'($urandom_range(0, WINDOW_HEIGHT_DEF + 1)) - 1;
				if (c < 0 || c > 127)
					c = $urandom_range(0, 127);
				if (r < 0 || r > 127)
					r = $urandom_range(0, 127);
			end
			src = $urandom;
			src[TILE_NUM_W-1:0] = pick_loaded();
			copy_tile(POS_W'(c), POS_W'(r), src, $urandom);
		end
	endtask

	task automatic test_random_phases();
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		for (int p = 0; p < 8; p++) begin
			set_windows(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord());
			for (int n = 0; n < 80; n++)
				random_word();
			wait_drained();
		end
	endtask

	// hold the output off long enough for the block to back up into its input
	task automatic test_backpressure();
		src_idle_en = 1'b0;
		set_windows(0, 0, 40, 30, 80, 60);
		hold_start = 1'b1;
		for (int n = 0; n < 40; n++)
			random_word();
		wait_drained();
		for (int n = 0; n < 20; n++)
			random_word();
		wait_drained();
	endtask

	task automatic test_full_rate();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		set_windows(-8, 120, 100, -4, 56, 56);
		for (int n = 0; n < 60; n++)
			random_word();
	endtask

	initial begin : run
		int waited;
		for (int i = 0; i < 6; i++)
			win_reg[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_windows();
		test_layer_priority();
		test_window_extremes();
		test_random_phases();
		test_backpressure();
		test_full_rate();
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("tilemap_copy_window_expose_test OK");
		else
			$display("tilemap_copy_window_expose_test NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/tcwe_pkg.sv
rtl/tcwe_ram.sv
rtl/tcwe_wrap.sv
rtl/tcwe_cover.sv
rtl/tilemap_copy_window_expose.sv
verif/tilemap_copy_window_expose_test.sv
